// ===== sv/ffpd_pkg.sv =====
// Package for the form field percent decoder: scan modes, escape phases,
// character constants, configuration and queue entry types, and decode functions.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package ffpd_pkg;

   typedef enum logic [1:0] {
      MODE_MATCH,
      MODE_SKIP,
      MODE_VALUE,
      MODE_AFTER
   } scan_mode_type;

   typedef enum logic [1:0] {
      ESC_NONE,
      ESC_PERCENT,
      ESC_HELD
   } escape_phase_type;

   localparam logic [7:0] CHAR_NUL     = 8'h00;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_AMP     = 8'h26;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_EQUALS  = 8'h3D;
   localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F = 8'h66;
   localparam logic [7:0] HEX_LETTER_BASE = 8'd10;

   localparam logic [1:0] REG_KEY_BYTES        = 2'd0;
   localparam logic [1:0] REG_KEY_LENGTH       = 2'd1;
   localparam logic [1:0] REG_MAX_VALUE_LENGTH = 2'd2;

   localparam logic [3:0] KEY_LENGTH_RESET       = 4'd4;
   localparam logic [7:0] MAX_VALUE_LENGTH_RESET = 8'd32;

   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [63:0] key_bytes;
      logic [3:0]  key_length;
      logic [7:0]  max_value_length;
   } cfg_type;

   typedef struct packed {
      logic [1:0] value_count;
      logic [7:0] value0;
      logic [7:0] value1;
      logic       status;
      logic       found;
   } bundle_type;

   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
         r = {1'b1, 4'(c - CHAR_DIGIT_0)};
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
         r = {1'b1, 4'(c - CHAR_LOWER_A + HEX_LETTER_BASE)};
      end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
         r = {1'b1, 4'(c - CHAR_UPPER_A + HEX_LETTER_BASE)};
      end
      return r;
   endfunction

   function automatic logic [7:0] escape_value(input logic [7:0] a, input logic [7:0] b);
      logic [4:0] da;
      logic [4:0] db;
      logic [7:0] r;
      da = hex_digit(a);
      db = hex_digit(b);
      r  = 8'd0;
      if (a == CHAR_SPACE || (a >= CHAR_TAB && a <= CHAR_CR) || a == CHAR_PLUS) begin
         r = db[4] ? {4'd0, db[3:0]} : 8'd0;
      end else if (a == CHAR_MINUS) begin
         r = db[4] ? 8'(8'd0 - {4'd0, db[3:0]}) : 8'd0;
      end else if (da[4]) begin
         r = db[4] ? {da[3:0], db[3:0]} : {4'd0, da[3:0]};
      end
      return r;
   endfunction

   function automatic logic [7:0] plus_to_space(input logic [7:0] c);
      return (c == CHAR_PLUS) ? CHAR_SPACE : c;
   endfunction

endpackage

// ===== sv/ffpd_front.sv =====
// Front end of the form field percent decoder: takes one body byte per cycle
// while the queue has room, tracks the field scan and escape state and builds
// one queue entry of results. Depends on ffpd_pkg.
`timescale 1ns / 1ps

module ffpd_front import ffpd_pkg::*; #(
   parameter int MAX_KEY_CHARS = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       in_push,
   input  logic [7:0] in_byte,
   input  logic       in_last,
   input  logic       q_full,
   output logic       q_push,
   output bundle_type q_data
);

   localparam int POS_W = $clog2(MAX_KEY_CHARS + 1);
   localparam logic [3:0] KEY_LIMIT = 4'(MAX_KEY_CHARS);

   scan_mode_type    mode_ff, mode_in, mode_t;
   escape_phase_type phase_ff, phase_in, phase_t, flush_phase;
   logic [POS_W-1:0] pos_ff, pos_in, pos_t;
   logic [7:0]       raw_ff, raw_in, raw_t, raw_next;
   logic [7:0]       held_ff, held_in, held_t, flush_held;
   logic             found_ff, found_in, found_t;
   logic             stopped_ff, stopped_in;

   logic       accept, zero_byte, body_end;
   logic       is_amp, is_eq, is_pct;
   logic [3:0] key_len;
   logic [2:0] key_idx;
   logic       pos_done, key_hit, raw_full, raw_next_full, value_end, max_zero;
   logic       take_v, flush_en, c0_v, c1_v, e0, e1, s1, s2;
   logic [7:0] take_c, c0, c1;

   assign accept    = in_push && !q_full;
   assign zero_byte = (in_byte == CHAR_NUL);
   assign body_end  = zero_byte || in_last;
   assign is_amp    = (in_byte == CHAR_AMP);
   assign is_eq     = (in_byte == CHAR_EQUALS);
   assign is_pct    = (in_byte == CHAR_PERCENT);
   assign key_len   = (cfg.key_length > KEY_LIMIT) ? KEY_LIMIT : cfg.key_length;
   assign key_idx   = 3'(pos_ff);
   assign pos_done  = (4'(pos_ff) >= key_len);
   assign key_hit   = !is_eq && (in_byte == cfg.key_bytes[{key_idx, 3'b000} +: 8]);
   assign raw_full  = (raw_ff >= cfg.max_value_length);
   assign raw_next  = raw_ff + 8'd1;
   assign raw_next_full = (raw_next >= cfg.max_value_length);
   assign value_end = is_amp || raw_full;
   assign max_zero  = (cfg.max_value_length == 8'd0);

   always_comb begin
      mode_t = mode_ff;
      if (!zero_byte) begin
         unique case (mode_ff)
            MODE_MATCH: begin
               if (is_amp) begin
                  mode_t = MODE_MATCH;
               end else if (pos_done) begin
                  if (is_eq) begin
                     mode_t = max_zero ? MODE_AFTER : MODE_VALUE;
                  end else begin
                     mode_t = MODE_SKIP;
                  end
               end else if (!key_hit) begin
                  mode_t = MODE_SKIP;
               end
            end
            MODE_SKIP: begin
               if (is_amp) mode_t = MODE_MATCH;
            end
            MODE_VALUE: begin
               if (value_end || raw_next_full) mode_t = MODE_AFTER;
            end
            MODE_AFTER: begin
               mode_t = MODE_AFTER;
            end
            default: begin
               mode_t = MODE_MATCH;
            end
         endcase
      end
      mode_in = mode_ff;
      if (accept) mode_in = body_end ? MODE_MATCH : mode_t;
   end

   always_comb begin
      pos_t       = pos_ff;
      raw_t       = raw_ff;
      phase_t     = phase_ff;
      held_t      = held_ff;
      found_t     = found_ff;
      take_v      = 1'b0;
      take_c      = CHAR_NUL;
      flush_en    = 1'b0;
      flush_phase = phase_ff;
      flush_held  = held_ff;
      if (!zero_byte) begin
         case (mode_ff)
            MODE_MATCH: begin
               if (is_amp) begin
                  pos_t = '0;
               end else if (pos_done) begin
                  if (is_eq) begin
                     found_t = 1'b1;
                     raw_t   = 8'd0;
                     phase_t = ESC_NONE;
                  end
               end else if (key_hit) begin
                  pos_t = pos_ff + 1'b1;
               end
            end
            MODE_SKIP: begin
               if (is_amp) pos_t = '0;
            end
            MODE_VALUE: begin
               if (value_end) begin
                  flush_en = 1'b1;
                  phase_t  = ESC_NONE;
               end else begin
                  raw_t = raw_next;
                  case (phase_ff)
                     ESC_NONE: begin
                        if (is_pct) begin
                           phase_t = ESC_PERCENT;
                        end else begin
                           take_v = 1'b1;
                           take_c = plus_to_space(in_byte);
                        end
                     end
                     ESC_PERCENT: begin
                        held_t  = in_byte;
                        phase_t = ESC_HELD;
                     end
                     default: begin
                        take_v  = 1'b1;
                        take_c  = escape_value(held_ff, in_byte);
                        phase_t = ESC_NONE;
                     end
                  endcase
                  if (raw_next_full) begin
                     flush_en    = 1'b1;
                     flush_phase = phase_t;
                     flush_held  = held_t;
                     phase_t     = ESC_NONE;
                  end
               end
            end
            default: begin
            end
         endcase
      end
      if (body_end && mode_t == MODE_VALUE) begin
         flush_en    = 1'b1;
         flush_phase = phase_t;
         flush_held  = held_t;
      end

      c0_v = take_v || (flush_en && flush_phase != ESC_NONE);
      c0   = take_v ? take_c : CHAR_PERCENT;
      c1_v = !take_v && flush_en && (flush_phase == ESC_HELD);
      c1   = plus_to_space(flush_held);
      e0   = c0_v && !stopped_ff;
      s1   = stopped_ff || (e0 && c0 == CHAR_NUL);
      e1   = c1_v && !s1;
      s2   = s1 || (e1 && c1 == CHAR_NUL);

      q_data.value_count = {1'b0, e0} + {1'b0, e1};
      q_data.value0      = e0 ? c0 : c1;
      q_data.value1      = c1;
      q_data.status      = body_end;
      q_data.found       = found_t;
      q_push             = accept && (e0 || e1 || body_end);

      pos_in     = pos_ff;
      raw_in     = raw_ff;
      phase_in   = phase_ff;
      held_in    = held_ff;
      found_in   = found_ff;
      stopped_in = stopped_ff;
      if (accept) begin
         held_in = held_t;
         if (body_end) begin
            pos_in     = '0;
            raw_in     = 8'd0;
            phase_in   = ESC_NONE;
            found_in   = 1'b0;
            stopped_in = 1'b0;
         end else begin
            pos_in     = pos_t;
            raw_in     = raw_t;
            phase_in   = phase_t;
            found_in   = found_t;
            stopped_in = s2;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_MATCH;
         pos_ff     <= '0;
         raw_ff     <= 8'd0;
         phase_ff   <= ESC_NONE;
         found_ff   <= 1'b0;
         stopped_ff <= 1'b0;
      end else begin
         mode_ff    <= mode_in;
         pos_ff     <= pos_in;
         raw_ff     <= raw_in;
         phase_ff   <= phase_in;
         found_ff   <= found_in;
         stopped_ff <= stopped_in;
      end
      held_ff <= held_in;
   end

endmodule

// ===== sv/ffpd_queue.sv =====
// Short queue of result entries between the front and back ends of the decoder.
// Depends on ffpd_pkg for the entry type and depth.
`timescale 1ns / 1ps

module ffpd_queue import ffpd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  bundle_type push_data,
   output logic       q_full,
   input  logic       q_pop,
   output bundle_type pop_data,
   output logic       q_empty
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_COUNT = CNT_W'(QUEUE_DEPTH);

   bundle_type       entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign q_full   = (count_ff == DEPTH_COUNT);
   assign q_empty  = (count_ff == '0);
   assign do_push  = push && !q_full;
   assign do_pop   = q_pop && !q_empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

// ===== sv/ffpd_back.sv =====
// Back end of the form field percent decoder: takes queue entries and hands
// their value and status results to the result channel one transfer at a time.
// Depends on ffpd_pkg.
`timescale 1ns / 1ps

module ffpd_back import ffpd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_empty,
   input  bundle_type q_data,
   output logic       q_pop,
   input  logic       pop,
   output logic       empty,
   output logic [7:0] rsp_value_byte,
   output logic       rsp_value_valid,
   output logic       rsp_done_res,
   output logic       rsp_found
);

   bundle_type cur_ff, cur_in;
   logic       cur_valid_ff, cur_valid_in;
   logic [1:0] idx_ff, idx_in;
   logic [1:0] total;
   logic       at_last, take, is_value;

   assign total    = cur_ff.value_count + {1'b0, cur_ff.status};
   assign at_last  = (idx_ff == total - 2'd1);
   assign take     = pop && cur_valid_ff;
   assign q_pop    = (!cur_valid_ff || (take && at_last)) && !q_empty;
   assign is_value = (idx_ff < cur_ff.value_count);

   assign empty           = !cur_valid_ff;
   assign rsp_value_byte  = is_value ? (idx_ff[0] ? cur_ff.value1 : cur_ff.value0) : CHAR_NUL;
   assign rsp_value_valid = is_value;
   assign rsp_done_res    = !is_value;
   assign rsp_found       = !is_value && cur_ff.found;

   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      idx_in       = idx_ff;
      if (q_pop) begin
         cur_in       = q_data;
         cur_valid_in = 1'b1;
         idx_in       = 2'd0;
      end else if (take) begin
         if (at_last) cur_valid_in = 1'b0;
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
      end
      cur_ff <= cur_in;
   end

endmodule

// ===== sv/form_field_percent_decoder_top.sv =====
// Form field percent decoder: the top level, with the configuration registers
// and the front end, entry queue and back end. Depends on ffpd_pkg, ffpd_front,
// ffpd_queue and ffpd_back.
//
// Body bytes arrive on the input queue port (push, full, req_body_byte,
// req_body_last); a zero byte or the last flag ends a body. Results leave on
// the output queue port (empty, pop, rsp_*): decoded value bytes of the first
// field whose name matches the key, then one status result with done and found
// at the body's end. The key and the value limit are set through the APB port.
// One byte is taken every cycle while the four-entry queue has room; each byte
// yields zero to three results, and the back end gives one result per cycle
// while pop is high, so a body streams at one byte per cycle unless bytes yield
// more than one result on average. Results pass the queue and back end registers.
// When the receiver stalls, results stay in the back end and the queue, and
// full rises once the queue is taken up. Reset restores the registers to their
// defaults, clears the scan state and empties the queue; no clearing pass.
`timescale 1ns / 1ps

module form_field_percent_decoder_top import ffpd_pkg::*; #(
   parameter int MAX_KEY_CHARS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_body_byte,
   input  logic        req_body_last,
   output logic        empty,
   input  logic        pop,
   output logic [7:0]  rsp_value_byte,
   output logic        rsp_value_valid,
   output logic        rsp_done_res,
   output logic        rsp_found,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready
);

   cfg_type    cfg_ff, cfg_in;
   logic       csr_write;
   logic [1:0] csr_index;
   logic       q_push, q_full, q_pop, q_empty;
   bundle_type q_in_data, q_out_data;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = paddr[4:3];
   assign full      = q_full;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_KEY_BYTES:        cfg_in.key_bytes        = pwdata;
            REG_KEY_LENGTH:       cfg_in.key_length       = pwdata[3:0];
            REG_MAX_VALUE_LENGTH: cfg_in.max_value_length = pwdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_KEY_BYTES:        prdata = cfg_ff.key_bytes;
         REG_KEY_LENGTH:       prdata = {60'd0, cfg_ff.key_length};
         REG_MAX_VALUE_LENGTH: prdata = {56'd0, cfg_ff.max_value_length};
         default:              prdata = 64'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.key_bytes        <= 64'd0;
         cfg_ff.key_length       <= KEY_LENGTH_RESET;
         cfg_ff.max_value_length <= MAX_VALUE_LENGTH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ffpd_front #(
      .MAX_KEY_CHARS(MAX_KEY_CHARS)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .in_push (push),
      .in_byte (req_body_byte),
      .in_last (req_body_last),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_data  (q_in_data)
   );

   ffpd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_data),
      .q_full    (q_full),
      .q_pop     (q_pop),
      .pop_data  (q_out_data),
      .q_empty   (q_empty)
   );

   ffpd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_data          (q_out_data),
      .q_pop           (q_pop),
      .pop             (pop),
      .empty           (empty),
      .rsp_value_byte  (rsp_value_byte),
      .rsp_value_valid (rsp_value_valid),
      .rsp_done_res    (rsp_done_res),
      .rsp_found       (rsp_found)
   );

   a_no_push_when_full : assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("Entry pushed into a full queue.");

   a_no_pop_when_empty : assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("Entry taken from an empty queue.");

   a_body_end_gives_result : assert property (@(posedge clock) disable iff (reset)
      (push && !full && (req_body_byte == CHAR_NUL || req_body_last)) |-> ##2 !empty)
      else $error("No result offered after the end of a body.");

endmodule

// ===== dv/form_field_percent_decoder_top_test.sv =====
// Testbench for form_field_percent_decoder_top: sends urlencoded bodies through the queue
// ports, sets the key and value limit over APB, and checks every result against a predictor.
// Depends on ffpd_pkg and the form_field_percent_decoder_top RTL.
`timescale 1ns / 1ps

module form_field_percent_decoder_top_test;
   import ffpd_pkg::*;

   localparam int KEY_CHAR_LIMIT = 8;
   localparam int ITEM_TARGET = 480;
   localparam int PHASE_ITEMS = 40;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 12;
   localparam int HOLD_CYCLES = 300;
   localparam string NAME_CHARS = "abkx019_.-";
   localparam string VALUE_CHARS = "%%%%++ -0123456789abcdefABCDEFgGz\t\v\r&=";

   typedef struct packed {
      logic [7:0] value_byte;
      logic       value_valid;
      logic       done_res;
      logic       found;
   } field_result_type;

   typedef struct packed {
      logic             is_write;
      logic [1:0]       reg_index;
      logic [63:0]      reg_value;
      logic [7:0]       body_byte;
      logic             body_last;
      logic             typed;
      field_result_type typed_result;
   } stimulus_row_type;

   localparam field_result_type STATUS_NOT_FOUND = {8'd0, 1'b0, 1'b1, 1'b0};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic [7:0]  req_body_byte = 8'd0;
   logic        req_body_last = 1'b0;
   logic        empty;
   logic        pop = 1'b0;
   logic [7:0]  rsp_value_byte;
   logic        rsp_value_valid;
   logic        rsp_done_res;
   logic        rsp_found;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [4:0]  paddr = 5'd0;
   logic [63:0] pwdata = 64'd0;
   logic [63:0] prdata;
   logic        pready;

   form_field_percent_decoder_top #(.MAX_KEY_CHARS(KEY_CHAR_LIMIT)) uut (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_body_byte(req_body_byte),
      .req_body_last(req_body_last),
      .empty(empty),
      .pop(pop),
      .rsp_value_byte(rsp_value_byte),
      .rsp_value_valid(rsp_value_valid),
      .rsp_done_res(rsp_done_res),
      .rsp_found(rsp_found),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Predictor copy of the registers and the per-body scan state.
   logic [63:0]      key_chars = 64'd0;
   logic [3:0]       key_len = KEY_LENGTH_RESET;
   logic [7:0]       value_limit = MAX_VALUE_LENGTH_RESET;
   scan_mode_type    mode = MODE_MATCH;
   int               name_pos = 0;
   int               raw_count = 0;
   escape_phase_type esc_phase = ESC_NONE;
   logic [7:0]       held_byte = 8'd0;
   logic             field_seen = 1'b0;
   logic             value_stopped = 1'b0;

   field_result_type decoded_q[$];
   stimulus_row_type stimulus_table[$];
   logic [8:0]       body_q[$];

   int unsigned mismatch_count = 0;
   int unsigned result_index = 0;
   int unsigned cycle_count = 0;
   int unsigned random_sent = 0;
   int unsigned holds_requested = 0;
   int unsigned holds_served = 0;
   int unsigned hold_left = 0;
   bit          calm = 1'b0;

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   function automatic int hex_nibble(input logic [7:0] c);
      if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
         return int'(c - CHAR_DIGIT_0);
      end
      if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
         return int'(c - CHAR_LOWER_A) + 10;
      end
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
         return int'(c - CHAR_UPPER_A) + 10;
      end
      return -1;
   endfunction

   // Mirrors a base 16 conversion of the two escape characters, keeping the low byte.
   function automatic logic [7:0] escape_byte(input logic [7:0] a, input logic [7:0] b);
      int hi;
      int lo;
      lo = hex_nibble(b);
      if (a == CHAR_SPACE || (a >= CHAR_TAB && a <= CHAR_CR)) begin
         return (lo < 0) ? 8'd0 : 8'(lo);
      end
      if (a == CHAR_PLUS || a == CHAR_MINUS) begin
         if (lo < 0) begin
            return 8'd0;
         end
         return (a == CHAR_MINUS) ? 8'(256 - lo) : 8'(lo);
      end
      hi = hex_nibble(a);
      if (hi < 0) begin
         return 8'd0;
      end
      if (lo < 0) begin
         return 8'(hi);
      end
      return 8'(hi * 16 + lo);
   endfunction

   function automatic void give_value(input logic [7:0] v);
      if (value_stopped) begin
         return;
      end
      decoded_q.push_back({v, 1'b1, 1'b0, 1'b0});
      if (v == CHAR_NUL) begin
         value_stopped = 1'b1;
      end
   endfunction

   function automatic void spill_escape();
      if (esc_phase != ESC_NONE) begin
         give_value(CHAR_PERCENT);
      end
      if (esc_phase == ESC_HELD) begin
         give_value(held_byte == CHAR_PLUS ? CHAR_SPACE : held_byte);
      end
      esc_phase = ESC_NONE;
   endfunction

   function automatic void scan_byte(input logic [7:0] b);
      int kl;
      kl = (key_len > KEY_CHAR_LIMIT) ? KEY_CHAR_LIMIT : int'(key_len);
      case (mode)
         MODE_MATCH: begin
            if (b == CHAR_AMP) begin
               name_pos = 0;
            end else if (name_pos >= kl) begin
               if (b == CHAR_EQUALS) begin
                  field_seen = 1'b1;
                  raw_count = 0;
                  esc_phase = ESC_NONE;
                  mode = (value_limit == 8'd0) ? MODE_AFTER : MODE_VALUE;
               end else begin
                  mode = MODE_SKIP;
               end
            end else if (b != CHAR_EQUALS && b == key_chars[8*name_pos +: 8]) begin
               name_pos++;
            end else begin
               mode = MODE_SKIP;
            end
         end
         MODE_SKIP: begin
            if (b == CHAR_AMP) begin
               mode = MODE_MATCH;
               name_pos = 0;
            end
         end
         MODE_VALUE: begin
            if (b == CHAR_AMP || raw_count >= value_limit) begin
               spill_escape();
               mode = MODE_AFTER;
            end else begin
               raw_count++;
               case (esc_phase)
                  ESC_NONE: begin
                     if (b == CHAR_PERCENT) begin
                        esc_phase = ESC_PERCENT;
                     end else begin
                        give_value(b == CHAR_PLUS ? CHAR_SPACE : b);
                     end
                  end
                  ESC_PERCENT: begin
                     held_byte = b;
                     esc_phase = ESC_HELD;
                  end
                  default: begin
                     give_value(escape_byte(held_byte, b));
                     esc_phase = ESC_NONE;
                  end
               endcase
               if (raw_count >= value_limit) begin
                  spill_escape();
                  mode = MODE_AFTER;
               end
            end
         end
         default: begin
         end
      endcase
   endfunction

   function automatic void predict_item(input logic [7:0] b, input logic last);
      if (b != CHAR_NUL) begin
         scan_byte(b);
      end
      if (b == CHAR_NUL || last) begin
         if (mode == MODE_VALUE) begin
            spill_escape();
         end
         decoded_q.push_back({8'd0, 1'b0, 1'b1, field_seen});
         mode = MODE_MATCH;
         name_pos = 0;
         raw_count = 0;
         esc_phase = ESC_NONE;
         held_byte = 8'd0;
         field_seen = 1'b0;
         value_stopped = 1'b0;
      end
   endfunction

   function automatic void add_byte(input logic [7:0] b, input logic last);
      stimulus_table.push_back({1'b0, REG_KEY_BYTES, 64'd0, b, last, 1'b0, 11'd0});
   endfunction

   function automatic void add_typed(input logic [7:0] b, input logic last,
                                     input field_result_type r);
      stimulus_table.push_back({1'b0, REG_KEY_BYTES, 64'd0, b, last, 1'b1, r});
   endfunction

   function automatic void add_write(input logic [1:0] idx, input logic [63:0] val);
      stimulus_table.push_back({1'b1, idx, val, 8'd0, 1'b0, 1'b0, 11'd0});
   endfunction

   function automatic logic [7:0] pick_char(input string pool);
      return pool[$urandom_range(pool.len() - 1)];
   endfunction

   function automatic logic [7:0] value_char();
      if ($urandom_range(9) == 0) begin
         return 8'($urandom_range(1, 255));
      end
      return pick_char(VALUE_CHARS);
   endfunction

   // Mostly well-formed bodies whose field names are built from the key, some noise.
   function automatic void build_body();
      int fields;
      int n;
      int kl;
      logic [7:0] c;
      body_q.delete();
      kl = (key_len > KEY_CHAR_LIMIT) ? KEY_CHAR_LIMIT : int'(key_len);
      if ($urandom_range(7) == 0) begin
         n = $urandom_range(1, 12);
         repeat (n) body_q.push_back({1'b0, 8'($urandom_range(1, 255))});
      end else begin
         fields = $urandom_range(1, 4);
         for (int f = 0; f < fields; f++) begin
            if (f > 0) begin
               body_q.push_back({1'b0, CHAR_AMP});
            end
            case ($urandom_range(9))
               0, 1, 2, 3, 4, 5: begin
                  for (int i = 0; i < kl; i++) begin
                     body_q.push_back({1'b0, key_chars[8*i +: 8]});
                  end
               end
               6: begin
                  for (int i = 0; i < kl; i++) begin
                     c = (i == kl - 1) ? pick_char(NAME_CHARS) : key_chars[8*i +: 8];
                     body_q.push_back({1'b0, c});
                  end
               end
               7: begin
                  for (int i = 0; i < kl; i++) begin
                     body_q.push_back({1'b0, key_chars[8*i +: 8]});
                  end
                  body_q.push_back({1'b0, pick_char(NAME_CHARS)});
               end
               default: begin
                  n = $urandom_range(1, 4);
                  repeat (n) body_q.push_back({1'b0, pick_char(NAME_CHARS)});
               end
            endcase
            if ($urandom_range(9) != 0) begin
               body_q.push_back({1'b0, CHAR_EQUALS});
            end
            n = $urandom_range(0, 14);
            repeat (n) body_q.push_back({1'b0, value_char()});
         end
      end
      if (body_q.size() == 0 || $urandom_range(4) == 0) begin
         body_q.push_back({1'($urandom_range(1)), CHAR_NUL});
      end else begin
         body_q[body_q.size() - 1][8] = 1'b1;
      end
   endfunction

   task automatic send_item(input logic [7:0] b, input logic last, input logic typed,
                            input field_result_type typed_result);
      int unsigned n0;
      while (!calm && $urandom_range(99) < 8) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_body_byte <= b;
      req_body_last <= last;
      do @(posedge clock); while (full);
      n0 = decoded_q.size();
      predict_item(b, last);
      if (typed) begin
         while (decoded_q.size() > n0) void'(decoded_q.pop_back());
         decoded_q.push_back(typed_result);
      end
   endtask

   task automatic write_register(input logic [1:0] idx, input logic [63:0] val);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 3'b000};
      pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_KEY_BYTES: key_chars = val;
         REG_KEY_LENGTH: key_len = val[3:0];
         REG_MAX_VALUE_LENGTH: value_limit = val[7:0];
         default: begin
         end
      endcase
   endtask

   task automatic wait_drained();
      push <= 1'b0;
      while (decoded_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin : result_check
      field_result_type seen;
      field_result_type want;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            seen = {rsp_value_byte, rsp_value_valid, rsp_done_res, rsp_found};
            if (decoded_q.size() == 0) begin
               report_mismatch($sformatf("result %0d arrived with nothing expected (%h)",
                                         result_index, seen));
            end else begin
               want = decoded_q.pop_front();
               if (seen.value_byte !== want.value_byte) begin
                  report_mismatch($sformatf("result %0d value_byte %h, expected %h",
                                            result_index, seen.value_byte, want.value_byte));
               end
               if (seen.value_valid !== want.value_valid) begin
                  report_mismatch($sformatf("result %0d value_valid %b, expected %b",
                                            result_index, seen.value_valid, want.value_valid));
               end
               if (seen.done_res !== want.done_res) begin
                  report_mismatch($sformatf("result %0d done_res %b, expected %b",
                                            result_index, seen.done_res, want.done_res));
               end
               if (seen.found !== want.found) begin
                  report_mismatch($sformatf("result %0d found %b, expected %b",
                                            result_index, seen.found, want.found));
               end
            end
            result_index++;
         end
         if (holds_served != holds_requested) begin
            holds_served++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
         end else begin
            pop <= calm || ($urandom_range(99) >= 8);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("form_field_percent_decoder_top verification failed");
         $finish;
      end
   end

   initial begin
      int phase;
      int unsigned phase_start;
      logic [63:0] key_pick;
      int klen_pick;
      int limit_pick;

      // Status after reset, the extreme byte, then a full escape walk on key "k".
      add_typed(CHAR_NUL, 1'b0, STATUS_NOT_FOUND);
      add_typed(8'hFF, 1'b1, STATUS_NOT_FOUND);
      add_write(REG_KEY_BYTES, 64'h6B);
      add_write(REG_KEY_LENGTH, 64'd1);
      add_write(REG_MAX_VALUE_LENGTH, 64'd255);
      add_byte("k", 1'b0);
      add_byte(CHAR_EQUALS, 1'b0);
      add_byte(CHAR_PERCENT, 1'b0);
      add_byte("4", 1'b0);
      add_byte("1", 1'b0);
      add_byte(CHAR_PLUS, 1'b0);
      add_byte(CHAR_PERCENT, 1'b0);
      add_byte(CHAR_MINUS, 1'b0);
      add_byte("5", 1'b0);
      add_byte(CHAR_PERCENT, 1'b0);
      add_byte(CHAR_SPACE, 1'b0);
      add_byte("f", 1'b0);
      add_byte(CHAR_PERCENT, 1'b0);
      add_byte("g", 1'b1);
      // Empty name with a one byte limit cuts an escape short.
      add_write(REG_KEY_LENGTH, 64'd0);
      add_write(REG_MAX_VALUE_LENGTH, 64'd1);
      add_byte(CHAR_EQUALS, 1'b0);
      add_byte(CHAR_PERCENT, 1'b0);
      add_byte("A", 1'b1);
      // A decoded zero byte.
      add_write(REG_KEY_LENGTH, 64'd1);
      add_write(REG_MAX_VALUE_LENGTH, 64'd255);
      add_byte("k", 1'b0);
      add_byte(CHAR_EQUALS, 1'b0);
      add_byte(CHAR_PERCENT, 1'b0);
      add_byte("0", 1'b0);
      add_byte("0", 1'b1);

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (stimulus_table[i]) begin
         if (stimulus_table[i].is_write) begin
            wait_drained();
            write_register(stimulus_table[i].reg_index, stimulus_table[i].reg_value);
         end else begin
            send_item(stimulus_table[i].body_byte, stimulus_table[i].body_last,
                      stimulus_table[i].typed, stimulus_table[i].typed_result);
         end
      end

      phase = 0;
      while (random_sent < ITEM_TARGET) begin
         wait_drained();
         if ($urandom_range(5) == 0) begin
            key_pick = {$urandom, $urandom};
         end else begin
            for (int i = 0; i < KEY_CHAR_LIMIT; i++) begin
               key_pick[8*i +: 8] = pick_char(NAME_CHARS);
            end
         end
         case (phase)
            0: begin
               klen_pick = 0;
               limit_pick = 0;
            end
            1: begin
               klen_pick = 1;
               limit_pick = 1;
            end
            2: begin
               klen_pick = 8;
               limit_pick = 255;
            end
            3: begin
               klen_pick = 15;
               limit_pick = 2;
            end
            default: begin
               klen_pick = $urandom_range(0, 15);
               limit_pick = ($urandom_range(4) == 0) ? $urandom_range(11, 255)
                                                     : $urandom_range(1, 10);
            end
         endcase
         write_register(REG_KEY_BYTES, key_pick);
         write_register(REG_KEY_LENGTH, 64'(klen_pick));
         write_register(REG_MAX_VALUE_LENGTH, 64'(limit_pick));
         calm = (phase == 2);
         if (phase == 4) begin
            holds_requested++;
         end
         phase_start = random_sent;
         while (random_sent - phase_start < PHASE_ITEMS && random_sent < ITEM_TARGET) begin
            build_body();
            foreach (body_q[i]) begin
               send_item(body_q[i][7:0], body_q[i][8], 1'b0, 11'd0);
               random_sent++;
            end
         end
         phase++;
      end
      calm = 1'b0;

      wait_drained();
      if (mismatch_count == 0) begin
         $display("form_field_percent_decoder_top verification clean");
      end else begin
         $display("form_field_percent_decoder_top verification failed");
      end
      $finish;
   end

endmodule
